// ===== src/bcf_pkg.sv =====
package bcf_pkg;

  localparam int NV        = 32;
  localparam int VW        = 6;
  localparam int VI_W      = $clog2(NV);
  localparam int MAX_EDGES = 128;
  localparam int NARCS     = 2 * MAX_EDGES;
  localparam int ARC_W     = $clog2(NARCS);
  localparam int EDGE_W    = $clog2(MAX_EDGES + 1);
  localparam int CLU_W     = 5;
  localparam int MASK_W    = 32;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_ANALYZE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_MEMBER  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic              accepted;
    logic [VW-1:0]     member_vertex;
    logic [CLU_W-1:0]  cluster_index;
    logic              cluster_end;
    logic [MASK_W-1:0] cutpoint_mask;
    logic [VW-1:0]     cutpoint_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [VW-1:0]    v;
    logic [VW-1:0]    par;
    logic [ARC_W-1:0] arc;
    logic             arc_ok;
    logic [VW-1:0]    kids;
    logic [VW-1:0]    low;
    logic [VW-1:0]    disc;
  } frame_t;

  typedef struct packed {
    logic [VW-1:0] p;
    logic [VW-1:0] c;
  } tree_t;

  typedef struct packed {
    logic             arc_en;
    logic [ARC_W-1:0] arc_addr;
    logic [VW-1:0]    head_v;
    logic [VW-1:0]    tail_v;
  } graph_rd_t;

  typedef struct packed {
    logic [VW-1:0]    target;
    logic [ARC_W-1:0] next;
    logic [ARC_W-1:0] head;
    logic             head_ok;
    logic [ARC_W-1:0] tail;
  } graph_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_ARC, S_ARCW, S_BACK, S_RET, S_POP, S_EMIT_U, S_TPOP, S_SUM
  } search_state_t;

  typedef enum logic [1:0] {T_IDLE, T_EDGE, T_ACK, T_SEARCH} top_state_t;

  function automatic logic [VI_W-1:0] vidx(input logic [VW-1:0] v);
    logic [VW-1:0] d;
    d = v - VW'(1);
    return d[VI_W-1:0];
  endfunction

endpackage

// ===== src/bcf_graph_store.sv =====
module bcf_graph_store import bcf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          add_start,
  input  logic          clear,
  input  logic [VW-1:0] add_u,
  input  logic [VW-1:0] add_v,
  input  logic [VW-1:0] n,
  output logic          add_ok,
  input  graph_rd_t     rd,
  output graph_rsp_t    rsp
);

  logic [VW-1:0]    target_mem [NARCS];
  logic [ARC_W-1:0] next_mem   [NARCS];
  logic [VW-1:0]    target_q;
  logic [ARC_W-1:0] next_q;

  logic [ARC_W-1:0] head [NV];
  logic [ARC_W-1:0] tail [NV];
  logic [NV-1:0]    hok;
  logic [EDGE_W-1:0] edges;
  logic             phase;
  logic [VW-1:0]    lat_u, lat_v;

  logic             wr;
  logic [VW-1:0]    from, to;
  logic [VI_W-1:0]  fi, tail_ix;
  logic [ARC_W-1:0] slot, tail_rd;

  assign add_ok = (add_u != '0) && (add_u <= n) && (add_v != '0) && (add_v <= n) &&
                  (edges < EDGE_W'(MAX_EDGES));

  always_comb begin
    wr      = (add_start && add_ok) || phase;
    from    = phase ? lat_v : add_u;
    to      = phase ? lat_u : add_v;
    fi      = vidx(from);
    slot    = ARC_W'({edges, phase});
    tail_ix = wr ? fi : vidx(rd.tail_v);
    tail_rd = tail[tail_ix];
  end

  // the tail arc's next entry is never used, so no end marker is stored
  always_ff @(posedge clk) begin
    if (wr) begin
      target_mem[slot] <= to;
      if (hok[fi]) next_mem[tail_rd] <= slot;
    end
    if (rd.arc_en) begin
      target_q <= target_mem[rd.arc_addr];
      next_q   <= next_mem[rd.arc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      tail[fi] <= slot;
      if (!hok[fi]) head[fi] <= slot;
    end
    if (add_start && add_ok) begin
      lat_u <= add_u;
      lat_v <= add_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hok   <= '0;
      edges <= '0;
      phase <= 1'b0;
    end else begin
      phase <= add_start && add_ok;
      if (wr) hok[fi] <= 1'b1;
      if (phase) edges <= edges + EDGE_W'(1);
    end
  end

  always_comb begin
    rsp.target  = target_q;
    rsp.next    = next_q;
    rsp.head    = head[vidx(rd.head_v)];
    rsp.head_ok = hok[vidx(rd.head_v)];
    rsp.tail    = tail_rd;
  end

endmodule

// ===== src/bcf_search.sv =====
module bcf_search import bcf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] n,
  output graph_rd_t     gq,
  input  graph_rsp_t    gr,
  output logic          emit_valid,
  output result_t       emit_res,
  input  logic          emit_ready
);

  search_state_t state, state_next;

  logic [VW-1:0]     root, root_next;
  frame_t            cur, cur_next;
  logic [VW-1:0]     sp, sp_next, esp, esp_next, tcnt, tcnt_next;
  logic [VW-1:0]     child_low, child_low_next, cuts, cuts_next;
  logic [CLU_W-1:0]  clusters, clusters_next;
  logic [MASK_W-1:0] mask, mask_next;
  logic [NV-1:0]     vis, vis_next;

  logic [VW-1:0] disc_mem [NV];
  frame_t        frame_mem [NV];
  tree_t         tree_mem [NV];
  logic [VW-1:0] disc_q;
  frame_t        frame_q;
  tree_t         tree_q;

  logic            disc_we, disc_re, frame_we, frame_re, tree_we, tree_re;
  logic [VI_W-1:0] disc_wa, disc_ra, frame_wa, frame_ra, tree_wa, tree_ra;
  logic [VW-1:0]   disc_wd, t_new;
  frame_t          frame_wd;
  tree_t           tree_wd;

  logic          mark_en;
  logic [VW-1:0] mark_v, w, vis_v;
  logic          is_last, visited;

  // each entry is written well before it is read back, no forwarding needed
  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    if (disc_re) disc_q <= disc_mem[disc_ra];
    if (frame_we) frame_mem[frame_wa] <= frame_wd;
    if (frame_re) frame_q <= frame_mem[frame_ra];
    if (tree_we) tree_mem[tree_wa] <= tree_wd;
    if (tree_re) tree_q <= tree_mem[tree_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    root      <= root_next;
    cur       <= cur_next;
    sp        <= sp_next;
    esp       <= esp_next;
    tcnt      <= tcnt_next;
    child_low <= child_low_next;
    cuts      <= cuts_next;
    clusters  <= clusters_next;
    mask      <= mask_next;
    vis       <= vis_next;
  end

  always_comb begin
    w       = gr.target;
    is_last = (cur.arc == gr.tail);
    vis_v   = (state == S_ROOT) ? root : w;
    visited = vis[vidx(vis_v)];
    t_new   = tcnt + VW'(1);

    gq.arc_en   = 1'b0;
    gq.arc_addr = cur.arc;
    gq.head_v   = vis_v;
    gq.tail_v   = cur.v;

    state_next     = state;
    root_next      = root;
    cur_next       = cur;
    sp_next        = sp;
    esp_next       = esp;
    tcnt_next      = tcnt;
    child_low_next = child_low;
    cuts_next      = cuts;
    clusters_next  = clusters;
    mask_next      = mask;
    vis_next       = vis;

    disc_we  = 1'b0;
    disc_wa  = vidx(vis_v);
    disc_wd  = t_new;
    disc_re  = 1'b0;
    disc_ra  = vidx(w);
    frame_we = 1'b0;
    frame_wa = sp[VI_W-1:0];
    frame_wd = cur;
    frame_re = 1'b0;
    frame_ra = VI_W'(sp - VW'(1));
    tree_we  = 1'b0;
    tree_wa  = esp[VI_W-1:0];
    tree_wd  = '{p: cur.v, c: w};
    tree_re  = 1'b0;
    tree_ra  = VI_W'(esp - VW'(1));

    mark_en    = 1'b0;
    mark_v     = cur.v;
    emit_valid = 1'b0;
    emit_res   = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          vis_next      = '0;
          mask_next     = '0;
          cuts_next     = '0;
          tcnt_next     = '0;
          root_next     = n;
          esp_next      = '0;
          clusters_next = '0;
          state_next    = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root == '0) begin
          state_next = S_SUM;
        end else if (visited) begin
          root_next = root - VW'(1);
        end else begin
          tcnt_next             = t_new;
          disc_we               = 1'b1;
          vis_next[vidx(root)]  = 1'b1;
          cur_next = '{v: root, par: '0, arc: gr.head, arc_ok: gr.head_ok,
                       kids: '0, low: t_new, disc: t_new};
          sp_next    = '0;
          tree_we    = 1'b1;
          tree_wd    = '{p: '0, c: root};
          esp_next   = esp + VW'(1);
          state_next = S_ARC;
        end
      end
      S_ARC: begin
        if (cur.arc_ok) begin
          gq.arc_en  = 1'b1;
          state_next = S_ARCW;
        end else begin
          state_next = S_RET;
        end
      end
      S_ARCW: begin
        cur_next.arc    = gr.next;
        cur_next.arc_ok = !is_last;
        if (w == cur.par || w == '0 || w > n) begin
          state_next = S_ARC;
        end else if (visited) begin
          disc_re    = 1'b1;
          state_next = S_BACK;
        end else begin
          // descend: spill the current frame, the child becomes current
          frame_we      = 1'b1;
          frame_wd      = cur;
          frame_wd.arc  = gr.next;
          frame_wd.arc_ok = !is_last;
          frame_wd.kids = cur.kids + VW'(1);
          sp_next       = sp + VW'(1);
          tcnt_next     = t_new;
          disc_we       = 1'b1;
          vis_next[vidx(w)] = 1'b1;
          tree_we       = 1'b1;
          esp_next      = esp + VW'(1);
          cur_next = '{v: w, par: cur.v, arc: gr.head, arc_ok: gr.head_ok,
                       kids: '0, low: t_new, disc: t_new};
          state_next = S_ARC;
        end
      end
      S_BACK: begin
        if (disc_q < cur.low) cur_next.low = disc_q;
        state_next = S_ARC;
      end
      S_RET: begin
        if (sp == '0) begin
          // root of a tree is a cutpoint only with two or more tree children
          if (cur.kids > VW'(1)) mark_en = 1'b1;
          root_next  = root - VW'(1);
          state_next = S_ROOT;
        end else begin
          frame_re       = 1'b1;
          child_low_next = cur.low;
          state_next     = S_POP;
        end
      end
      S_POP: begin
        cur_next     = frame_q;
        cur_next.low = (child_low < frame_q.low) ? child_low : frame_q.low;
        sp_next      = sp - VW'(1);
        if (child_low >= frame_q.disc) begin
          if (frame_q.par != '0) begin
            mark_en = 1'b1;
            mark_v  = frame_q.v;
          end
          state_next = S_EMIT_U;
        end else begin
          state_next = S_ARC;
        end
      end
      S_EMIT_U: begin
        emit_valid             = 1'b1;
        emit_res.kind          = KIND_MEMBER;
        emit_res.member_vertex = cur.v;
        emit_res.cluster_index = clusters;
        if (emit_ready) begin
          tree_re    = 1'b1;
          esp_next   = esp - VW'(1);
          state_next = S_TPOP;
        end
      end
      S_TPOP: begin
        emit_valid             = 1'b1;
        emit_res.kind          = KIND_MEMBER;
        emit_res.member_vertex = tree_q.c;
        emit_res.cluster_index = clusters;
        emit_res.cluster_end   = (tree_q.p == cur.v);
        if (emit_ready) begin
          if (tree_q.p == cur.v) begin
            clusters_next = clusters + CLU_W'(1);
            state_next    = S_ARC;
          end else begin
            tree_re  = 1'b1;
            esp_next = esp - VW'(1);
          end
        end
      end
      S_SUM: begin
        emit_valid              = 1'b1;
        emit_res.kind           = KIND_SUMMARY;
        emit_res.cutpoint_mask  = mask;
        emit_res.cutpoint_count = cuts;
        emit_res.last           = 1'b1;
        if (emit_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (mark_en && !mask[vidx(mark_v)]) begin
      mask_next[vidx(mark_v)] = 1'b1;
      cuts_next               = cuts + VW'(1);
    end
  end

endmodule

// ===== src/biconnected_component_finder.sv =====
// biconnected component finder
// config: cfg_we/cfg_wdata write vertex_count (reset 32, values above 32 act as 32)
// input stream s_*: s_tuser = opcode, s_tdata = vertex_u, vertex_v
//   add edge: both arcs written into the arc memory, then one ack (no writes when rejected)
//   clear: empties the graph, one ack; unknown opcode: ack with accepted 0
//   analyze: depth-first search over the adjacency lists; each arc is an arc
//   memory read then a decode, plus a discovery-time read when its target is
//   already visited; retiring a vertex takes end of list, return, frame pop;
//   root candidates are tried in turn and each cluster member is emitted;
//   the summary closes the run with tlast
// output stream m_*: m_tuser = kind, m_tlast = last result of the transaction
// one transaction is in work at a time; the next is taken as soon as the
// previous one has handed its final result to the output register
// a stalled receiver holds the output register and stalls the search at its next result
// reset (synchronous, rst high) empties the graph and sets vertex_count to 32;
// no clearing pass is needed
module biconnected_component_finder import bcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // vertex_u[5:0], vertex_v[11:6], zeros
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // accepted, member_vertex, cluster_index, cluster_end,
                                 // cutpoint_mask, cutpoint_count, zeros
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);

  top_state_t state, state_next;
  logic [VW-1:0] vertex_count, n;
  logic          ack_acc, ack_acc_next;
  logic          out_valid;
  result_t       out_res;

  logic          take, emit_ready, add_ok;
  logic          add_start, clr, srch_start;
  logic          s_emit_valid, emit_valid;
  result_t       s_emit_res, emit_res;
  graph_rd_t     gq;
  graph_rsp_t    gr;

  assign n = (vertex_count > VW'(NV)) ? VW'(NV) : vertex_count;
  assign s_tready = (state == T_IDLE);
  assign take = s_tvalid && s_tready;
  assign emit_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VW'(32);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_ready) out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    ack_acc <= ack_acc_next;
    if (emit_ready && emit_valid) out_res <= emit_res;
  end

  always_comb begin
    state_next   = state;
    ack_acc_next = ack_acc;
    add_start    = 1'b0;
    clr          = 1'b0;
    srch_start   = 1'b0;
    emit_valid   = 1'b0;
    emit_res     = '0;
    unique case (state)
      T_IDLE: begin
        if (take) begin
          ack_acc_next = 1'b0;
          state_next   = T_ACK;
          if (s_tuser == OP_ADD) begin
            add_start    = 1'b1;
            ack_acc_next = add_ok;
            if (add_ok) state_next = T_EDGE;
          end else if (s_tuser == OP_CLEAR) begin
            clr          = 1'b1;
            ack_acc_next = 1'b1;
          end else if (s_tuser == OP_ANALYZE) begin
            srch_start = 1'b1;
            state_next = T_SEARCH;
          end
        end
      end
      T_EDGE: state_next = T_ACK;
      T_ACK: begin
        emit_valid        = 1'b1;
        emit_res.kind     = KIND_ACK;
        emit_res.accepted = ack_acc;
        emit_res.last     = 1'b1;
        if (emit_ready) state_next = T_IDLE;
      end
      T_SEARCH: begin
        emit_valid = s_emit_valid;
        emit_res   = s_emit_res;
        if (s_emit_valid && s_emit_res.last && emit_ready) state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  bcf_graph_store u_store (
    .clk       (clk),
    .rst       (rst),
    .add_start (add_start),
    .clear     (clr),
    .add_u     (s_tdata[5:0]),
    .add_v     (s_tdata[11:6]),
    .n         (n),
    .add_ok    (add_ok),
    .rd        (gq),
    .rsp       (gr)
  );

  bcf_search u_search (
    .clk        (clk),
    .rst        (rst),
    .start      (srch_start),
    .n          (n),
    .gq         (gq),
    .gr         (gr),
    .emit_valid (s_emit_valid),
    .emit_res   (s_emit_res),
    .emit_ready (emit_ready && state == T_SEARCH)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {5'b0, out_res.cutpoint_count, out_res.cutpoint_mask,
                     out_res.cluster_end, out_res.cluster_index,
                     out_res.member_vertex, out_res.accepted};

endmodule

// ===== src/bcf_checker.sv =====
module bcf_checker import bcf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output payload changed under stall");

  a_end_kinds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ACK || m_tuser == KIND_SUMMARY) |-> m_tlast)
    else $error("ack or summary without tlast");

  a_member: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_MEMBER |-> !m_tlast && m_tdata[6:1] != 6'd0)
    else $error("bad cluster member transaction");

endmodule

bind biconnected_component_finder bcf_checker u_bcf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
